// ----- hw/rtl/u8sd_pkg.sv -----
`timescale 1ns / 1ps

package u8sd_pkg;

	localparam int unsigned ByteW     = 8;
	localparam int unsigned CpW       = 21;
	localparam int unsigned LenW      = 3;
	localparam int unsigned HeldW     = 2;
	localparam int unsigned CntW      = 3;

	localparam logic [CpW-1:0] ReplChar   = 21'h00FFFD;
	localparam logic [CpW-1:0] Min2Byte   = 21'h000080;
	localparam logic [CpW-1:0] Min3Byte   = 21'h000800;
	localparam logic [CpW-1:0] Min4Byte   = 21'h010000;
	localparam logic [CpW-1:0] SurrLo     = 21'h00D800;
	localparam logic [CpW-1:0] SurrHi     = 21'h00DFFF;
	localparam logic [CpW-1:0] MaxScalar  = 21'h10FFFF;

	localparam logic [LenW-1:0] LenNone = 3'd0;
	localparam logic [LenW-1:0] Len2    = 3'd2;
	localparam logic [LenW-1:0] Len3    = 3'd3;
	localparam logic [LenW-1:0] Len4    = 3'd4;

	typedef struct packed {
		logic [CntW-1:0] cnt;
		logic [CpW-1:0]  cp;
		logic            rep;
	} burst_t;

	function automatic logic [LenW-1:0] lead_len(input logic [ByteW-1:0] b);
		logic [LenW-1:0] len;
		len = LenNone;
		if ((b & 8'hE0) == 8'hC0) begin
			len = Len2;
		end else if ((b & 8'hF0) == 8'hE0) begin
			len = Len3;
		end else if ((b & 8'hF8) == 8'hF0) begin
			len = Len4;
		end
		return len;
	endfunction

	function automatic logic [CpW-1:0] lead_bits(input logic [ByteW-1:0] b,
			input logic [LenW-1:0] len);
		logic [CpW-1:0] v;
		case (len)
			Len2:    v = {16'd0, b[4:0]};
			Len3:    v = {17'd0, b[3:0]};
			Len4:    v = {18'd0, b[2:0]};
			default: v = '0;
		endcase
		return v;
	endfunction

	function automatic logic value_invalid(input logic [LenW-1:0] len,
			input logic [CpW-1:0] v);
		logic overlong;
		overlong = ((len == Len2) && (v < Min2Byte)) ||
			((len == Len3) && (v < Min3Byte)) ||
			((len == Len4) && (v < Min4Byte));
		return overlong || ((v >= SurrLo) && (v <= SurrHi)) || (v > MaxScalar);
	endfunction

endpackage

// ----- hw/rtl/u8sd_in_if.sv -----
`timescale 1ns / 1ps

interface u8sd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_text;

	modport source (output valid, output data_byte, output end_of_text, input ready);
	modport sink (input valid, input data_byte, input end_of_text, output ready);
endinterface

// ----- hw/rtl/u8sd_out_if.sv -----
`timescale 1ns / 1ps

interface u8sd_out_if;
	logic        valid;
	logic        ready;
	logic [20:0] code_point;
	logic        replaced;
	logic        last_of_run;

	modport source (output valid, output code_point, output replaced, output last_of_run,
		input ready);
	modport sink (input valid, input code_point, input replaced, input last_of_run,
		output ready);
endinterface

// ----- hw/rtl/utf8_stream_decoder.sv -----
`timescale 1ns / 1ps

// channel   dir   word                                      handshake
// text      in    data_byte[7:0], end_of_text              valid / ready
// points    out   code_point[20:0], replaced, last_of_run  valid / ready
//
// one byte per cycle while points.ready holds and every byte gives at most one code point
// a byte giving n code points holds the result register until all n are taken (n up to 4)
// a byte passes the byte register and then the result register before its first code point appears
// reset leaves no sequence held and both registers empty
// a stalled output backs up through the single byte register to text.ready

module utf8_stream_decoder (
	input  logic        clk,
	input  logic        arst_n,
	u8sd_in_if.sink     text,
	u8sd_out_if.source  points
);
	import u8sd_pkg::*;

	logic             s1_valid_q;
	logic [ByteW-1:0] byte_s1;
	logic             eot_s1;

	logic [CpW-1:0]   pv_q;
	logic [LenW-1:0]  len_q;
	logic [HeldW-1:0] held_q;

	logic [CntW-1:0]  rem_q;
	logic [CpW-1:0]   last_cp_q;
	logic             last_rep_q;

	burst_t           burst;
	logic [CpW-1:0]   nx_pv;
	logic [LenW-1:0]  nx_len;
	logic [HeldW-1:0] nx_held;

	logic             is_cont;
	logic [LenW-1:0]  blen;
	logic [CpW-1:0]   pv_cat;
	logic [HeldW-1:0] held_inc;
	logic [CntW-1:0]  base;
	logic             out_free;
	logic             retire;

	// sequence decode for the byte in the input register
	always_comb begin
		nx_pv     = pv_q;
		nx_len    = len_q;
		nx_held   = held_q;
		burst.cnt = '0;
		burst.cp  = ReplChar;
		burst.rep = 1'b1;
		is_cont   = (byte_s1[7:6] == 2'b10);
		blen      = lead_len(byte_s1);
		pv_cat    = {pv_q[CpW-7:0], byte_s1[5:0]};
		held_inc  = held_q + 2'd1;
		base      = (len_q != LenNone) ? ({1'b0, held_q} + 3'd1) : 3'd0;

		if ((len_q != LenNone) && is_cont) begin
			nx_pv   = pv_cat;
			nx_held = held_inc;
			if (({1'b0, held_inc} + 3'd1) >= len_q) begin
				burst.cnt = 3'd1;
				if (!value_invalid(len_q, pv_cat)) begin
					burst.cp  = pv_cat;
					burst.rep = 1'b0;
				end
				nx_pv   = '0;
				nx_len  = LenNone;
				nx_held = '0;
			end else if (eot_s1) begin
				// end of text mid-sequence: flush lead and continuations
				burst.cnt = {1'b0, held_inc} + 3'd1;
				nx_pv     = '0;
				nx_len    = LenNone;
				nx_held   = '0;
			end
		end else begin
			nx_pv   = '0;
			nx_len  = LenNone;
			nx_held = '0;
			if (byte_s1[7] == 1'b0) begin
				burst.cnt = base + 3'd1;
				burst.cp  = {13'd0, byte_s1};
				burst.rep = 1'b0;
			end else if (blen != LenNone) begin
				if (eot_s1) begin
					burst.cnt = base + 3'd1;
				end else begin
					burst.cnt = base;
					nx_len    = blen;
					nx_pv     = lead_bits(byte_s1, blen);
				end
			end else begin
				burst.cnt = base + 3'd1;
			end
		end
	end

	assign out_free    = (rem_q == 3'd0) || ((rem_q == 3'd1) && points.ready);
	assign retire      = s1_valid_q && ((burst.cnt == 3'd0) || out_free);
	assign text.ready  = !s1_valid_q || retire;

	assign points.valid       = (rem_q != 3'd0);
	assign points.last_of_run = (rem_q == 3'd1);
	assign points.code_point  = (rem_q == 3'd1) ? last_cp_q : ReplChar;
	assign points.replaced    = (rem_q == 3'd1) ? last_rep_q : 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (text.valid && text.ready) begin
			s1_valid_q <= 1'b1;
		end else if (retire) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (text.valid && text.ready) begin
			byte_s1 <= text.data_byte;
			eot_s1  <= text.end_of_text;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_q   <= '0;
			len_q  <= LenNone;
			held_q <= '0;
		end else if (retire) begin
			pv_q   <= nx_pv;
			len_q  <= nx_len;
			held_q <= nx_held;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (retire && (burst.cnt != 3'd0)) begin
			rem_q <= burst.cnt;
		end else if (points.valid && points.ready) begin
			rem_q <= rem_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (retire && (burst.cnt != 3'd0)) begin
			last_cp_q  <= burst.cp;
			last_rep_q <= burst.rep;
		end
	end

	a_idle_no_held: assert property (@(posedge clk) disable iff (!arst_n)
		(len_q == LenNone) |-> (held_q == '0))
		else $error("continuations held with no open sequence");

	a_held_below_len: assert property (@(posedge clk) disable iff (!arst_n)
		(len_q != LenNone) |-> (({1'b0, held_q} + 3'd1) < len_q))
		else $error("complete sequence left held");

	a_early_is_repl: assert property (@(posedge clk) disable iff (!arst_n)
		(points.valid && !points.last_of_run) |->
		(points.replaced && (points.code_point == ReplChar)))
		else $error("non-final word of a run is not a replacement");

	a_burst_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q <= 3'd4)
		else $error("more than four words pending");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!s1_valid_q |-> text.ready)
		else $error("input stalled with empty byte register");

endmodule

// ----- dv/utf8_stream_decoder_tb.sv -----
`timescale 1ns / 1ps

module utf8_stream_decoder_tb;
	import u8sd_pkg::*;

	localparam int CycleLimit = 200000;
	localparam int RandomBytes = 225;
	localparam int HoldOffCycles = 400;

	class code_point_board;
		typedef struct {
			logic [CpW-1:0] cp;
			logic           rep;
			logic           last;
		} point_t;

		point_t          pending_points[$];
		point_t          byte_points[$];
		logic [CpW-1:0]  partial;
		logic [LenW-1:0] seq_len;
		logic [HeldW-1:0] held;
		int              errors;

		function new();
			partial = '0;
			seq_len = LenNone;
			held = '0;
			errors = 0;
		endfunction

		function void push_point(logic [CpW-1:0] cp, logic rep);
			point_t p;
			p.cp = cp;
			p.rep = rep;
			p.last = 1'b0;
			byte_points.push_back(p);
		endfunction

		function void clear_seq();
			partial = '0;
			seq_len = LenNone;
			held = '0;
		endfunction

		// one replacement for the lead, one per continuation
		function void flush_seq();
			push_point(ReplChar, 1'b1);
			for (int k = 0; k < held; k++) push_point(ReplChar, 1'b1);
			clear_seq();
		endfunction

		function void start_byte(logic [7:0] b);
			if (b < 8'h80) begin
				push_point({13'd0, b}, 1'b0);
			end else if ((b & 8'hE0) == 8'hC0) begin
				seq_len = Len2;
				partial = {16'd0, b[4:0]};
				held = '0;
			end else if ((b & 8'hF0) == 8'hE0) begin
				seq_len = Len3;
				partial = {17'd0, b[3:0]};
				held = '0;
			end else if ((b & 8'hF8) == 8'hF0) begin
				seq_len = Len4;
				partial = {18'd0, b[2:0]};
				held = '0;
			end else begin
				push_point(ReplChar, 1'b1);
			end
		endfunction

		function void note_byte(logic [7:0] b, logic eot);
			logic bad;
			byte_points.delete();
			if (seq_len != LenNone && b[7:6] == 2'b10) begin
				partial = {partial[CpW-7:0], b[5:0]};
				held = held + 1'b1;
				if (int'(held) + 1 >= int'(seq_len)) begin
					bad = (seq_len == Len2 && partial < Min2Byte) ||
						(seq_len == Len3 && partial < Min3Byte) ||
						(seq_len == Len4 && partial < Min4Byte) ||
						(partial >= SurrLo && partial <= SurrHi) ||
						(partial > MaxScalar);
					if (bad) push_point(ReplChar, 1'b1);
					else push_point(partial, 1'b0);
					clear_seq();
				end else if (eot) begin
					flush_seq();
				end
			end else begin
				if (seq_len != LenNone) flush_seq();
				start_byte(b);
				if (seq_len != LenNone && eot) flush_seq();
			end
			if (byte_points.size() > 0) byte_points[$].last = 1'b1;
			foreach (byte_points[i]) pending_points.push_back(byte_points[i]);
		endfunction

		function void check_point(logic [CpW-1:0] cp, logic rep, logic last);
			point_t p;
			if (pending_points.size() == 0) begin
				$error("unexpected code point %h (replaced %b, last_of_run %b)", cp, rep, last);
				errors++;
			end else begin
				p = pending_points.pop_front();
				if (cp !== p.cp) begin
					$error("code_point: expected %h, got %h", p.cp, cp);
					errors++;
				end
				if (rep !== p.rep) begin
					$error("replaced: expected %b, got %b", p.rep, rep);
					errors++;
				end
				if (last !== p.last) begin
					$error("last_of_run: expected %b, got %b", p.last, last);
					errors++;
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	u8sd_in_if  text_if ();
	u8sd_out_if points_if ();

	utf8_stream_decoder uut (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text_if),
		.points (points_if)
	);

	code_point_board board = new();

	int  cycle_count = 0;
	int  bytes_sent = 0;
	int  send_burst = 0;
	int  rx_burst = 0;
	int  rx_stall = 0;
	logic hold_off = 1'b0;

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// zero gap during a burst, otherwise a random gap or the start of a new burst
	function automatic int draw_gap(inout int burst_left);
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		if ($urandom_range(0, 19) == 0) begin
			burst_left = $urandom_range(10, 40);
			return 0;
		end
		return $urandom_range(0, 14);
	endfunction

	always @(negedge clk) begin
		if (!arst_n) begin
			points_if.ready <= 1'b0;
		end else if (rx_stall > 0) begin
			points_if.ready <= 1'b0;
			rx_stall--;
		end else begin
			points_if.ready <= !hold_off;
		end
	end

	always @(posedge clk) begin
		if (arst_n && points_if.valid && points_if.ready) begin
			board.check_point(points_if.code_point, points_if.replaced, points_if.last_of_run);
			rx_stall = draw_gap(rx_burst);
		end
	end

	// long receiver stall so the byte path backs up
	initial begin
		wait (bytes_sent >= 90);
		@(posedge clk);
		hold_off = 1'b1;
		repeat (HoldOffCycles) @(posedge clk);
		hold_off = 1'b0;
	end

	task automatic send_byte(input logic [7:0] b, input logic eot);
		int gap;
		gap = draw_gap(send_burst);
		@(negedge clk);
		if (gap > 0) begin
			text_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		text_if.valid <= 1'b1;
		text_if.data_byte <= b;
		text_if.end_of_text <= eot;
		do @(posedge clk); while (!text_if.ready);
		board.note_byte(b, eot);
		bytes_sent++;
	endtask

	function automatic void encode(input logic [CpW-1:0] cp, input int len,
			ref logic [7:0] q[$]);
		case (len)
			1: q.push_back({1'b0, cp[6:0]});
			2: begin
				q.push_back({3'b110, cp[10:6]});
				q.push_back({2'b10, cp[5:0]});
			end
			3: begin
				q.push_back({4'b1110, cp[15:12]});
				q.push_back({2'b10, cp[11:6]});
				q.push_back({2'b10, cp[5:0]});
			end
			default: begin
				q.push_back({5'b11110, cp[20:18]});
				q.push_back({2'b10, cp[17:12]});
				q.push_back({2'b10, cp[11:6]});
				q.push_back({2'b10, cp[5:0]});
			end
		endcase
	endfunction

	task automatic send_random_sequence();
		logic [7:0] q[$];
		int kind;
		int len;
		int cut;
		kind = $urandom_range(0, 15);
		case (kind)
			0, 1, 2: encode(CpW'($urandom_range(0, 8'h7F)), 1, q);
			3, 4: encode(CpW'($urandom_range(12'h080, 12'h7FF)), 2, q);
			5, 6: encode(CpW'($urandom_range(16'h0800, 16'hFFFF)), 3, q);
			7, 8: encode(CpW'($urandom_range(21'h10000, 21'h10FFFF)), 4, q);
			9: encode(CpW'($urandom_range(0, 21'h1FFFFF)), 4, q);
			10: begin
				len = $urandom_range(2, 4);
				if (len == 2) encode(CpW'($urandom_range(0, 8'h7F)), 2, q);
				else if (len == 3) encode(CpW'($urandom_range(0, 12'h7FF)), 3, q);
				else encode(CpW'($urandom_range(0, 16'hFFFF)), 4, q);
			end
			11: encode(CpW'($urandom_range(16'hD800, 16'hDFFF)), 3, q);
			12: begin
				len = $urandom_range(2, 4);
				if (len == 2) encode(CpW'($urandom_range(12'h080, 12'h7FF)), 2, q);
				else if (len == 3) encode(CpW'($urandom_range(16'h0800, 16'hFFFF)), 3, q);
				else encode(CpW'($urandom_range(21'h10000, 21'h10FFFF)), 4, q);
				cut = $urandom_range(1, len - 1);
				repeat (cut) void'(q.pop_back());
			end
			13: q.push_back(8'($urandom_range(8'h80, 8'hBF)));
			14: q.push_back(8'($urandom_range(8'hF8, 8'hFF)));
			default: q.push_back(8'($urandom_range(0, 8'hFF)));
		endcase
		foreach (q[i]) send_byte(q[i], $urandom_range(0, 9) == 0);
	endtask

	initial begin
		logic [8:0] directed [25] = '{
			9'h000,
			9'h0C2, 9'h0A9,
			9'h0F0, 9'h09F, 9'h098, 9'h080,
			9'h080,
			9'h0FF,
			9'h0C0, 9'h080,
			9'h0ED, 9'h0A0, 9'h080,
			9'h0F4, 9'h090, 9'h080, 9'h080,
			9'h0F0, 9'h09F, 9'h098, 9'h07F,
			9'h1C3,
			9'h0E2, 9'h182
		};
		arst_n = 1'b0;
		text_if.valid = 1'b0;
		text_if.data_byte = '0;
		text_if.end_of_text = 1'b0;
		points_if.ready = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed[i]) send_byte(directed[i][7:0], directed[i][8]);
		while (bytes_sent < 25 + RandomBytes) send_random_sequence();
		@(negedge clk);
		text_if.valid <= 1'b0;

		while (board.pending_points.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);

		if (board.errors == 0 && board.pending_points.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
